// ===== rtl/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// text console with cursor and scrolling.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

  localparam int unsigned SCREEN_WIDTH  = 80;
  localparam int unsigned SCREEN_HEIGHT = 25;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned CELL_W   = 16;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic REG_SCROLL_ENABLE = 1'b0;

  localparam logic [OPCODE_W-1:0] OP_PUT_CURSOR = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUT_POS    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_CURSOR = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SET_COLOR  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ       = 3'd5;

  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0]  CHAR_BLANK    = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_DEFAULT = 8'h0F;
  localparam logic [CELL_W-1:0]  BLANK_CELL    = {COLOR_DEFAULT, CHAR_BLANK};

  typedef struct packed {
    logic in_load;
    logic exec;
    logic scroll_rd;
    logic scroll_wr;
    logic fill_wr;
    logic cnt_zero;
    logic cnt_last_row;
    logic cnt_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scroll_req;
    logic is_clear;
    logic cnt_copy_end;
    logic cnt_end;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/tccs_req_if.sv =====
// ----------------------------------------------------------------------------
// tccs_req_if
// Request channel: one console command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tccs_req_if;
  logic                             valid;
  logic                             ready;
  logic [tccs_pkg::OPCODE_W-1:0]    opcode;
  logic [tccs_pkg::CHAR_W-1:0]      char_code;
  logic [tccs_pkg::ROW_W-1:0]       row_pos;
  logic [tccs_pkg::COL_W-1:0]       col_pos;
  logic [tccs_pkg::COLOR_W-1:0]     color_value;

  modport source (
    output valid, opcode, char_code, row_pos, col_pos, color_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, char_code, row_pos, col_pos, color_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tccs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tccs_rsp_if
// Response channel: read cell, cursor and color after each command.
// ----------------------------------------------------------------------------
`default_nettype none

interface tccs_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [tccs_pkg::CELL_W-1:0]      cell_data;
  logic [tccs_pkg::ROW_W-1:0]       cursor_row;
  logic [tccs_pkg::COL_W-1:0]       cursor_col;
  logic [tccs_pkg::COLOR_W-1:0]     current_color;

  modport source (
    output valid, cell_data, cursor_row, cursor_col, current_color,
    input  ready
  );

  modport sink (
    input  valid, cell_data, cursor_row, cursor_col, current_color,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/text_console_cursor_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Text console with a screen store of 16-bit cells, cursor, color and
// scroll-on-bottom, driven by one command per request transaction.
//
//   port      dir  handshake        payload
//   req_i     in   valid/ready      opcode, char_code, row_pos, col_pos,
//                                   color_value
//   rsp_o     out  valid/ready      cell_data, cursor_row, cursor_col,
//                                   current_color
//   apb       in   psel/penable     register 0: scroll_enable
//
// Ordinary commands step through accept, execute and load response.
// Clear adds a fill of every cell; a scroll adds a copy of W*H-W cells,
// each read and then written, and a fill of the last row, all on the
// single store port. After reset the store is filled with blank cells before
// the first request is accepted; register writes are taken throughout.
// A stalled response holds in its register while the next request is
// accepted and executed.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll_unit #(
  parameter int unsigned SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tccs_req_if.sink                            req_i,
  tccs_rsp_if.source                          rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tccs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tccs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tccs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  tccs_pkg::cmd_t cmd;
  tccs_pkg::sts_t sts;
  logic           scroll_en_q;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tccs_pkg::REG_SCROLL_ENABLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_en_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      scroll_en_q <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? {{(tccs_pkg::APB_DATA_W-1){1'b0}}, scroll_en_q} : '0;

  tccs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tccs_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .scroll_en_i     (scroll_en_q),
    .opcode_i        (req_i.opcode),
    .char_code_i     (req_i.char_code),
    .row_pos_i       (req_i.row_pos),
    .col_pos_i       (req_i.col_pos),
    .color_value_i   (req_i.color_value),
    .cell_data_o     (rsp_o.cell_data),
    .cursor_row_o    (rsp_o.cursor_row),
    .cursor_col_o    (rsp_o.cursor_col),
    .current_color_o (rsp_o.current_color)
  );

endmodule

`default_nettype wire

// ===== rtl/tccs_dp.sv =====
// ----------------------------------------------------------------------------
// tccs_dp
// Datapath: screen store, cursor and color registers, sweep counter,
// command and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_dp #(
  parameter int unsigned SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tccs_pkg::cmd_t                    cmd_i,
  output tccs_pkg::sts_t                    sts_o,
  input  logic                              scroll_en_i,
  input  logic [tccs_pkg::OPCODE_W-1:0]     opcode_i,
  input  logic [tccs_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tccs_pkg::ROW_W-1:0]        row_pos_i,
  input  logic [tccs_pkg::COL_W-1:0]        col_pos_i,
  input  logic [tccs_pkg::COLOR_W-1:0]      color_value_i,
  output logic [tccs_pkg::CELL_W-1:0]       cell_data_o,
  output logic [tccs_pkg::ROW_W-1:0]        cursor_row_o,
  output logic [tccs_pkg::COL_W-1:0]        cursor_col_o,
  output logic [tccs_pkg::COLOR_W-1:0]      current_color_o
);

  localparam int unsigned NumCells = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AddrW    = $clog2(NumCells);
  localparam int unsigned RowW     = $clog2(SCREEN_HEIGHT);
  localparam int unsigned ColW     = $clog2(SCREEN_WIDTH);

  localparam logic [RowW-1:0]  LastRow      = RowW'(SCREEN_HEIGHT - 1);
  localparam logic [ColW-1:0]  LastCol      = ColW'(SCREEN_WIDTH - 1);
  localparam logic [AddrW-1:0] Width        = AddrW'(SCREEN_WIDTH);
  localparam logic [AddrW-1:0] LastCell     = AddrW'(NumCells - 1);
  localparam logic [AddrW-1:0] LastRowStart = AddrW'(NumCells - SCREEN_WIDTH);
  localparam logic [AddrW-1:0] LastCopy     = AddrW'(NumCells - SCREEN_WIDTH - 1);

  logic [tccs_pkg::CELL_W-1:0]   cells_q [NumCells];
  logic [tccs_pkg::CELL_W-1:0]   rd_q;

  logic [tccs_pkg::OPCODE_W-1:0] op_q;
  logic [tccs_pkg::CHAR_W-1:0]   char_q;
  logic [tccs_pkg::ROW_W-1:0]    row_in_q;
  logic [tccs_pkg::COL_W-1:0]    col_in_q;
  logic [tccs_pkg::COLOR_W-1:0]  color_in_q;

  logic [RowW-1:0]               cur_row_q, cur_row_d;
  logic [ColW-1:0]               cur_col_q, cur_col_d;
  logic [tccs_pkg::COLOR_W-1:0]  attr_q, attr_d;
  logic [AddrW-1:0]              cnt_q, cnt_d;

  logic [tccs_pkg::CELL_W-1:0]   cell_out_q;
  logic [tccs_pkg::ROW_W-1:0]    row_out_q;
  logic [tccs_pkg::COL_W-1:0]    col_out_q;
  logic [tccs_pkg::COLOR_W-1:0]  color_out_q;

  logic [RowW-1:0]               row_clamp;
  logic [ColW-1:0]               col_clamp;
  logic [AddrW-1:0]              pos_addr, cur_addr;
  logic                          is_newline, at_last_col, at_last_row, row_adv;

  logic                          we, re;
  logic [AddrW-1:0]              wa, ra;
  logic [tccs_pkg::CELL_W-1:0]   wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q       <= opcode_i;
      char_q     <= char_code_i;
      row_in_q   <= row_pos_i;
      col_in_q   <= col_pos_i;
      color_in_q <= color_value_i;
    end
  end

  always_comb begin
    if (32'(row_in_q) > 32'(SCREEN_HEIGHT - 1)) begin
      row_clamp = LastRow;
    end else begin
      row_clamp = RowW'(row_in_q);
    end
    if (32'(col_in_q) > 32'(SCREEN_WIDTH - 1)) begin
      col_clamp = LastCol;
    end else begin
      col_clamp = ColW'(col_in_q);
    end
  end

  assign pos_addr    = AddrW'(row_clamp) * Width + AddrW'(col_clamp);
  assign cur_addr    = AddrW'(cur_row_q) * Width + AddrW'(cur_col_q);
  assign is_newline  = (char_q == tccs_pkg::CHAR_NEWLINE);
  assign at_last_col = (cur_col_q == LastCol);
  assign at_last_row = (cur_row_q == LastRow);
  assign row_adv     = is_newline || at_last_col;

  assign sts_o.scroll_req   = (op_q == tccs_pkg::OP_PUT_CURSOR) && row_adv && at_last_row &&
                              scroll_en_i;
  assign sts_o.is_clear     = (op_q == tccs_pkg::OP_CLEAR);
  assign sts_o.cnt_copy_end = (cnt_q == LastCopy);
  assign sts_o.cnt_end      = (cnt_q == LastCell);

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    attr_d    = attr_q;
    if (cmd_i.exec) begin
      unique case (op_q)
        tccs_pkg::OP_PUT_CURSOR: begin
          if (row_adv) begin
            cur_col_d = '0;
            if (!at_last_row) begin
              cur_row_d = cur_row_q + RowW'(1);
            end else if (scroll_en_i) begin
              cur_row_d = LastRow;
              attr_d    = tccs_pkg::COLOR_DEFAULT;
            end else begin
              cur_row_d = '0;
            end
          end else begin
            cur_col_d = cur_col_q + ColW'(1);
          end
        end
        tccs_pkg::OP_SET_CURSOR: begin
          cur_row_d = row_clamp;
          cur_col_d = col_clamp;
        end
        tccs_pkg::OP_SET_COLOR: begin
          attr_d = color_in_q;
        end
        tccs_pkg::OP_CLEAR: begin
          cur_row_d = '0;
          cur_col_d = '0;
          attr_d    = tccs_pkg::COLOR_DEFAULT;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    priority if (cmd_i.cnt_zero) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_last_row) begin
      cnt_d = LastRowStart;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + AddrW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = cnt_q;
    wd = tccs_pkg::BLANK_CELL;
    priority if (cmd_i.fill_wr) begin
      we = 1'b1;
    end else if (cmd_i.scroll_wr) begin
      we = 1'b1;
      wd = rd_q;
    end else if (cmd_i.exec) begin
      if (op_q == tccs_pkg::OP_PUT_CURSOR && !is_newline) begin
        we = 1'b1;
        wa = cur_addr;
        wd = {attr_q, char_q};
      end else if (op_q == tccs_pkg::OP_PUT_POS) begin
        we = 1'b1;
        wa = pos_addr;
        wd = {attr_q, char_q};
      end
    end else begin
      we = 1'b0;
    end
  end

  assign re = cmd_i.scroll_rd || (cmd_i.exec && op_q == tccs_pkg::OP_READ);
  assign ra = cmd_i.scroll_rd ? (cnt_q + Width) : pos_addr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      cells_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= cells_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
      attr_q    <= tccs_pkg::COLOR_DEFAULT;
      cnt_q     <= '0;
    end else begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      attr_q    <= attr_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cell_out_q  <= (op_q == tccs_pkg::OP_READ) ? rd_q : '0;
      row_out_q   <= tccs_pkg::ROW_W'(cur_row_q);
      col_out_q   <= tccs_pkg::COL_W'(cur_col_q);
      color_out_q <= attr_q;
    end
  end

  assign cell_data_o     = cell_out_q;
  assign cursor_row_o    = row_out_q;
  assign cursor_col_o    = col_out_q;
  assign current_color_o = color_out_q;

endmodule

`default_nettype wire

// ===== rtl/tccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccs_ctrl
// Controller: sequences command execution, scroll copy, screen fill and the
// response register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  tccs_pkg::sts_t sts_i,
  output tccs_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_INIT      = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_EXEC      = 7'b0000100,
    ST_SCROLL_RD = 7'b0001000,
    ST_SCROLL_WR = 7'b0010000,
    ST_FILL      = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.cnt_end) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec     = 1'b1;
        cmd_o.cnt_zero = 1'b1;
        if (sts_i.scroll_req) begin
          state_d = ST_SCROLL_RD;
        end else if (sts_i.is_clear) begin
          state_d = ST_FILL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL_RD: begin
        cmd_o.scroll_rd = 1'b1;
        state_d         = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        cmd_o.scroll_wr = 1'b1;
        if (sts_i.cnt_copy_end) begin
          cmd_o.cnt_last_row = 1'b1;
          state_d            = ST_FILL;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_SCROLL_RD;
        end
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.cnt_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("response overwritten before taken");

  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $past(req_valid_i && req_ready_o))
    else $error("execute without accepted command");

  a_copy_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL_WR) |-> $past(state_q == ST_SCROLL_RD))
    else $error("scroll write without preceding read");
`endif

endmodule

`default_nettype wire

// ===== test/tccs_console_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tccs_console_checker
// Keeps its own copy of the screen store, cursor, color and scroll setting.
// Every accepted command is applied to that copy and the resulting status is
// queued; every accepted response is compared field by field against the
// oldest queued status. Register writes are picked up from the APB port.
// ----------------------------------------------------------------------------
module tccs_console_checker
  import tccs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tccs_req_if                   req_i,
  tccs_rsp_if                   rsp_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int                    mismatches_o,
  output int                    outstanding_o,
  output int                    checked_o,
  output int                    scrolls_o,
  output int                    wraps_o
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam logic [APB_ADDR_W-1:0] SCROLL_ADDR = APB_ADDR_W'(4 * REG_SCROLL_ENABLE);

  typedef struct packed {
    logic [CELL_W-1:0]  cell_word;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COLOR_W-1:0] color;
  } console_status_t;

  logic [CELL_W-1:0]  screen_m [CELLS];
  int                 cur_row_m;
  int                 cur_col_m;
  logic [COLOR_W-1:0] attr_m;
  logic               scroll_on;
  console_status_t    status_due_q [$];

  function automatic int clamp_to(int v, int top_val);
    return (v > top_val) ? top_val : v;
  endfunction

  task automatic blank_screen();
    int i;
    for (i = 0; i < CELLS; i++) screen_m[i] = BLANK_CELL;
  endtask

  task automatic advance_row();
    int i;
    cur_row_m++;
    if (cur_row_m >= SCREEN_HEIGHT) begin
      if (scroll_on) begin
        for (i = 0; i < CELLS - SCREEN_WIDTH; i++) screen_m[i] = screen_m[i + SCREEN_WIDTH];
        for (i = CELLS - SCREEN_WIDTH; i < CELLS; i++) screen_m[i] = BLANK_CELL;
        attr_m    = COLOR_DEFAULT;
        cur_row_m = SCREEN_HEIGHT - 1;
        cur_col_m = 0;
        scrolls_o++;
      end else begin
        cur_row_m = 0;
        wraps_o++;
      end
    end
  endtask

  task automatic predict_console_step(
    input  logic [OPCODE_W-1:0] op,
    input  logic [CHAR_W-1:0]   ch,
    input  logic [ROW_W-1:0]    row_in,
    input  logic [COL_W-1:0]    col_in,
    input  logic [COLOR_W-1:0]  color_in,
    output console_status_t     st
  );
    int                r;
    int                c;
    logic [CELL_W-1:0] read_word;
    r         = clamp_to(int'(row_in), SCREEN_HEIGHT - 1);
    c         = clamp_to(int'(col_in), SCREEN_WIDTH - 1);
    read_word = '0;
    case (op)
      OP_PUT_CURSOR: begin
        if (ch == CHAR_NEWLINE) begin
          advance_row();
          cur_col_m = 0;
        end else begin
          screen_m[cur_row_m * SCREEN_WIDTH + cur_col_m] = {attr_m, ch};
          cur_col_m++;
          if (cur_col_m >= SCREEN_WIDTH) begin
            cur_col_m = 0;
            advance_row();
          end
        end
      end
      OP_PUT_POS: screen_m[r * SCREEN_WIDTH + c] = {attr_m, ch};
      OP_SET_CURSOR: begin
        cur_row_m = r;
        cur_col_m = c;
      end
      OP_SET_COLOR: attr_m = color_in;
      OP_CLEAR: begin
        blank_screen();
        cur_row_m = 0;
        cur_col_m = 0;
        attr_m    = COLOR_DEFAULT;
      end
      OP_READ: read_word = screen_m[r * SCREEN_WIDTH + c];
      default: ;
    endcase
    st.cell_word = read_word;
    st.row       = ROW_W'(cur_row_m);
    st.col       = COL_W'(cur_col_m);
    st.color     = attr_m;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    console_status_t want;
    console_status_t got;
    if (!rst_ni) begin
      blank_screen();
      cur_row_m     = 0;
      cur_col_m     = 0;
      attr_m        = COLOR_DEFAULT;
      scroll_on     = 1'b1;
      mismatches_o  = 0;
      checked_o     = 0;
      scrolls_o     = 0;
      wraps_o       = 0;
      status_due_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SCROLL_ADDR) begin
        scroll_on = pwdata_i[0];
      end
      if (req_i.valid && req_i.ready) begin
        predict_console_step(req_i.opcode, req_i.char_code, req_i.row_pos,
                             req_i.col_pos, req_i.color_value, want);
        status_due_q.push_back(want);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.cell_word = rsp_i.cell_data;
        got.row       = rsp_i.cursor_row;
        got.col       = rsp_i.cursor_col;
        got.color     = rsp_i.current_color;
        if (status_due_q.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("%0t: response with nothing pending: cell %h row %0d col %0d color %h",
                     $time, got.cell_word, got.row, got.col, got.color);
          end
          mismatches_o++;
        end else begin
          want = status_due_q.pop_front();
          checked_o++;
          if (got.cell_word !== want.cell_word || got.row !== want.row ||
              got.col !== want.col || got.color !== want.color) begin
            if (mismatches_o < 10) begin
              $display("%0t: mismatch: expected cell %h row %0d col %0d color %h",
                       $time, want.cell_word, want.row, want.col, want.color);
              $display("%0t:           got      cell %h row %0d col %0d color %h",
                       $time, got.cell_word, got.row, got.col, got.color);
            end
            mismatches_o++;
          end
        end
      end
    end
    outstanding_o = status_due_q.size();
  end

endmodule

// ===== test/text_console_cursor_scroll_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit_tb
// Drives console commands and a scroll-enable register into the console,
// with random bursts of idling on both channels. A short directed sequence
// hits the field extremes, clamping, wrap, scroll, clear and spare opcodes;
// random phases follow with scrolling on and off. The checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit_tb;
  import tccs_pkg::*;

  localparam logic [OPCODE_W-1:0]   OP_SPARE_LO   = 3'd6;
  localparam logic [OPCODE_W-1:0]   OP_SPARE_HI   = 3'd7;
  localparam logic [APB_ADDR_W-1:0] SCROLL_ADDR   = APB_ADDR_W'(4 * REG_SCROLL_ENABLE);
  localparam int                    PHASES        = 4;
  localparam int                    PHASE_ITEMS   = 150;
  localparam int                    TAIL_ITEMS    = 50;
  localparam int                    DRAIN_LIMIT   = 20000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int outstanding;
  int checked;
  int scrolls;
  int wraps;
  int sent;
  int cfg_errors;
  int stall_left;
  bit bursty;
  bit drained;

  tccs_req_if req_if ();
  tccs_rsp_if rsp_if ();

  text_console_cursor_scroll_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tccs_console_checker console_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .scrolls_o     (scrolls),
    .wraps_o       (wraps)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #150_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else if (bursty && $urandom_range(0, 9) == 0) begin
        rsp_if.ready = 1'b0;
        stall_left   = $urandom_range(1, 19) - 1;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  task automatic send_cmd(
    input logic [OPCODE_W-1:0] op,
    input logic [CHAR_W-1:0]   ch,
    input logic [ROW_W-1:0]    row,
    input logic [COL_W-1:0]    col,
    input logic [COLOR_W-1:0]  color
  );
    req_if.opcode      = op;
    req_if.char_code   = ch;
    req_if.row_pos     = row;
    req_if.col_pos     = col;
    req_if.color_value = color;
    req_if.valid       = 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sent++;
    @(negedge clk_i);
    if (bursty && $urandom_range(0, 7) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  task automatic send_random();
    int                  pick;
    logic [OPCODE_W-1:0] op;
    logic [CHAR_W-1:0]   ch;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [COLOR_W-1:0]  color;
    pick  = $urandom_range(0, 99);
    ch    = CHAR_W'($urandom_range(0, 255));
    row   = ROW_W'($urandom_range(0, 31));
    col   = COL_W'($urandom_range(0, 127));
    color = COLOR_W'($urandom_range(0, 255));
    if (pick < 45) begin
      op = OP_PUT_CURSOR;
      if ($urandom_range(0, 6) == 0) ch = CHAR_NEWLINE;
      else if ($urandom_range(0, 1) == 0) ch = CHAR_W'($urandom_range(32, 126));
    end else if (pick < 55) begin
      op = OP_PUT_POS;
    end else if (pick < 67) begin
      op = OP_SET_CURSOR;
      if ($urandom_range(0, 1) == 0) begin
        row = ROW_W'($urandom_range(SCREEN_HEIGHT - 3, 31));
        col = COL_W'($urandom_range(SCREEN_WIDTH - 20, 127));
      end
    end else if (pick < 75) begin
      op = OP_SET_COLOR;
    end else if (pick < 95) begin
      op = OP_READ;
      if ($urandom_range(0, 1) == 0) row = ROW_W'($urandom_range(SCREEN_HEIGHT - 5, 31));
    end else if (pick < 97) begin
      op = OP_CLEAR;
    end else begin
      op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
    end
    send_cmd(op, ch, row, col, color);
  endtask

  task automatic cfg_access(input logic write, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = SCROLL_ADDR;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_scroll(input logic enable);
    logic [APB_DATA_W-1:0] rdata;
    cfg_access(1'b1, APB_DATA_W'(enable), rdata);
    cfg_access(1'b0, '0, rdata);
    if (rdata[0] !== enable) begin
      $display("%0t: scroll_enable reads %h after writing %0d", $time, rdata, enable);
      cfg_errors++;
    end
  endtask

  task automatic wait_drained();
    int n;
    n            = 0;
    req_if.valid = 1'b0;
    while (outstanding != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk_i);
      n++;
    end
    if (outstanding != 0) drained = 1'b0;
  endtask

  initial begin : stimulus
    int ph;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_PUT_CURSOR;
    req_if.char_code   = '0;
    req_if.row_pos     = '0;
    req_if.col_pos     = '0;
    req_if.color_value = '0;
    sent               = 0;
    cfg_errors         = 0;
    bursty             = 1'b1;
    drained            = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_scroll(1'b1);
    send_cmd(OP_READ,       8'h00, 5'd0,  7'd0,   8'h00);
    send_cmd(OP_READ,       8'hFF, 5'd31, 7'd127, 8'hFF);
    send_cmd(OP_SET_COLOR,  8'h00, 5'd0,  7'd0,   8'h00);
    send_cmd(OP_PUT_CURSOR, 8'h00, 5'd31, 7'd127, 8'hFF);
    send_cmd(OP_SET_COLOR,  8'hFF, 5'd0,  7'd0,   8'hFF);
    send_cmd(OP_PUT_CURSOR, 8'hFF, 5'd0,  7'd0,   8'h00);
    send_cmd(OP_PUT_CURSOR, CHAR_NEWLINE, 5'd0, 7'd0, 8'h00);
    send_cmd(OP_PUT_POS,    8'h41, 5'd31, 7'd127, 8'h00);
    send_cmd(OP_READ,       8'h00, 5'd24, 7'd79,  8'h00);
    send_cmd(OP_READ,       8'h00, 5'd0,  7'd0,   8'h00);
    send_cmd(OP_READ,       8'h00, 5'd0,  7'd1,   8'h00);
    send_cmd(OP_SET_CURSOR, 8'h00, 5'd31, 7'd127, 8'h00);
    send_cmd(OP_PUT_CURSOR, 8'h5A, 5'd0,  7'd0,   8'h00);
    send_cmd(OP_READ,       8'h00, 5'd23, 7'd79,  8'h00);
    send_cmd(OP_PUT_CURSOR, CHAR_NEWLINE, 5'd0, 7'd0, 8'h00);
    send_cmd(OP_READ,       8'h00, 5'd22, 7'd79,  8'h00);
    send_cmd(OP_SPARE_LO,   8'hFF, 5'd31, 7'd127, 8'hFF);
    send_cmd(OP_SPARE_HI,   8'h00, 5'd0,  7'd0,   8'h00);
    send_cmd(OP_CLEAR,      8'h00, 5'd0,  7'd0,   8'h00);
    send_cmd(OP_READ,       8'h00, 5'd22, 7'd79,  8'h00);

    wait_drained();
    set_scroll(1'b0);
    send_cmd(OP_SET_CURSOR, 8'h00, 5'd24, 7'd79,  8'h00);
    send_cmd(OP_PUT_CURSOR, 8'h71, 5'd0,  7'd0,   8'h00);
    send_cmd(OP_SET_CURSOR, 8'h00, 5'd24, 7'd5,   8'h00);
    send_cmd(OP_PUT_CURSOR, CHAR_NEWLINE, 5'd0, 7'd0, 8'h00);
    send_cmd(OP_READ,       8'h00, 5'd24, 7'd79,  8'h00);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      set_scroll((ph % 2) == 0);
      repeat (PHASE_ITEMS) send_random();
    end

    // drop all idling for the closing stretch
    wait_drained();
    set_scroll(1'b1);
    bursty = 1'b0;
    repeat (TAIL_ITEMS) send_random();

    wait_drained();
    repeat (50) @(negedge clk_i);
    $display("covered %0d commands with scrolling on and off, %0d responses checked",
             sent, checked);
    $display("predicted %0d scrolls and %0d row wraps", scrolls, wraps);
    if (drained && mismatches == 0 && cfg_errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
